### src/spicf_pkg.sv
// Shared types, constants and CRC helpers for the SPI command frame responder.
// No dependencies; imported by spi_command_frame_responder.
package spicf_pkg;

  // Default sizes
  localparam int SENSOR_BYTES_DEF = 16;
  localparam int FRAME_LENGTH_DEF = 5;

  // Configuration port
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_POLY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REFLECT = 2'd2;

  localparam logic [15:0] CRC_POLY_RST = 16'h1021;
  localparam logic [15:0] CRC_INIT_RST = 16'h0000;

  // Input function codes
  localparam logic [1:0] FUNC_RX     = 2'd0;
  localparam logic [1:0] FUNC_SENSOR = 2'd1;
  localparam logic [1:0] FUNC_STATUS = 2'd2;
  localparam logic [1:0] FUNC_MSTATE = 2'd3;

  // Protocol bytes
  localparam logic [7:0] START_BYTE = 8'hAA;
  localparam logic [7:0] PASS_BYTE  = 8'hAA;
  localparam logic [7:0] FAIL_BYTE  = 8'hF0;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_CRC,
    ST_ANSWER,
    ST_BURST_RD,
    ST_BURST_LD,
    ST_BURST_EMIT,
    ST_BURST_CRC,
    ST_CRC_LO,
    ST_CRC_HI
  } resp_state_t;

  // One bit of a CRC-16 update, message bit fed most significant first
  function automatic logic [15:0] crc_bit_step(input logic [15:0] crc,
                                               input logic [15:0] poly,
                                               input logic        din);
    logic fb;
    fb = crc[15] ^ din;
    return {crc[14:0], 1'b0} ^ (fb ? poly : 16'h0000);
  endfunction

  // Reverse the bit order of a 16-bit word
  function automatic logic [15:0] rev16(input logic [15:0] v);
    logic [15:0] r;
    for (int i = 0; i < 16; i++) begin
      r[i] = v[15-i];
    end
    return r;
  endfunction

endpackage

### src/spicf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the sensor buffer.
module spicf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/spi_command_frame_responder.sv
// SPI command frame responder: frames received bytes, checks CRC-16, answers bursts.
// Depends on spicf_pkg and spicf_ram.
//
// Usage:
//   in_*  : one transaction per received SPI byte (in_func = receive) or per
//           write of a sensor, status or machine-state byte.
//   out_* : transmit-queue transactions; out_flush_tx discards queued bytes,
//           out_last marks the final result of an input transaction.
//   cfg_* : CRC polynomial, initial value and reflect flag; write only while idle.
// Sequencing (one bit of CRC per cycle through a single shared CRC step unit):
//   - writes and non-final frame bytes: handled in idle, next transaction the cycle after.
//   - start byte (0xAA): one flush result, issued from the flush state.
//   - final frame byte: CRC over the first FRAME_LENGTH-2 bytes, then the answer.
//   - burst trigger: for each of the SENSOR_BYTES+2 burst bytes, sensor RAM read,
//     load and output states, then the CRC unit over its bits; then two CRC bytes.
// in_ready is high only while the sequencer is idle. A stalled receiver holds
// the output register and the sequencer waits in the state that emits the result.
// Reset clears the configuration to its defaults, the frame and transfer state,
// the status bytes and the sensor valid bits (unwritten sensors read as zero).
module spi_command_frame_responder #(
  parameter int SENSOR_BYTES = spicf_pkg::SENSOR_BYTES_DEF,
  parameter int FRAME_LENGTH = spicf_pkg::FRAME_LENGTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_func,
  input  logic [7:0]                     in_data_byte,
  input  logic [3:0]                     in_sensor_index,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_tx_byte,
  output logic                           out_flush_tx,
  output logic                           out_last,
  output logic                           out_transfer_active,
  input  logic                           cfg_we,
  input  logic [spicf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spicf_pkg::CFG_W-1:0]    cfg_wdata
);

  import spicf_pkg::*;

  localparam int SAW = (SENSOR_BYTES > 1) ? $clog2(SENSOR_BYTES) : 1;
  localparam int BIW = $clog2(SENSOR_BYTES + 2);
  localparam int FIW = $clog2(FRAME_LENGTH);

  localparam logic [BIW-1:0] IDX_STATUS = BIW'(SENSOR_BYTES);
  localparam logic [BIW-1:0] IDX_MSTATE = BIW'(SENSOR_BYTES + 1);
  localparam logic [FIW-1:0] FRAME_CRC_LAST = FIW'(FRAME_LENGTH - 3);
  localparam logic [FIW-1:0] REM_OPEN       = FIW'(FRAME_LENGTH - 1);
  localparam logic [FIW-1:0] FRAME_LEN_F    = FIW'(FRAME_LENGTH);

  // Configuration
  logic [15:0] poly_r, init_r;
  logic        reflect_r;

  // Sequencer and frame state
  resp_state_t      state_r, state_nxt;
  logic [FIW-1:0]   remaining_r, remaining_nxt;
  logic             cmd_ok_r, cmd_ok_nxt;
  logic             flag_r, flag_nxt;
  logic [7:0]       status_r, status_nxt;
  logic [7:0]       mstate_r, mstate_nxt;
  logic [FIW-1:0]   fidx_r, fidx_nxt;
  logic [BIW-1:0]   bidx_r, bidx_nxt;
  logic [2:0]       bit_r, bit_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       cur_byte_r, cur_byte_nxt;
  logic             vld_q_r, vld_q_nxt;

  // Frame byte store
  logic [7:0]       frame_r [FRAME_LENGTH];
  logic             frame_we;
  logic [FIW-1:0]   frame_widx;

  // Sensor buffer
  logic [SENSOR_BYTES-1:0] sens_vld_r;
  logic                    ram_we, ram_re;
  logic [SAW-1:0]          ram_waddr, ram_raddr;
  logic [7:0]              ram_rdata;
  logic                    sens_rd;

  // Output register
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_tx_r, out_tx_nxt;
  logic       out_flush_r, out_flush_nxt;
  logic       out_last_r, out_last_nxt;
  logic       out_act_r, out_act_nxt;

  // Shared CRC unit
  logic        in_fire, slot_free;
  logic [7:0]  crc_src;
  logic        crc_din;
  logic [15:0] crc_step, crc_fin;
  logic [15:0] frame_got;
  logic        sidx_ok;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  assign crc_src  = (state_r == ST_CRC) ? frame_r[fidx_r] : cur_byte_r;
  assign crc_din  = reflect_r ? crc_src[bit_r] : crc_src[~bit_r];
  assign crc_step = crc_bit_step(crc_r, poly_r, crc_din);
  assign crc_fin  = reflect_r ? rev16(crc_r) : crc_r;
  assign frame_got = {frame_r[FRAME_LENGTH-1], frame_r[FRAME_LENGTH-2]};

  assign sidx_ok   = (32'(in_sensor_index) < 32'(SENSOR_BYTES));
  assign ram_waddr = SAW'(in_sensor_index);
  assign ram_raddr = bidx_r[SAW-1:0];
  assign sens_rd   = (bidx_r < IDX_STATUS);

  spicf_ram #(
    .WIDTH (8),
    .DEPTH (SENSOR_BYTES),
    .AW    (SAW)
  ) u_sensor_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_data_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r    <= CRC_POLY_RST;
      init_r    <= CRC_INIT_RST;
      reflect_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POLY:    poly_r    <= cfg_wdata;
        CFG_INIT:    init_r    <= cfg_wdata;
        CFG_REFLECT: reflect_r <= cfg_wdata[0];
        default:     ;
      endcase
    end
  end

  // Sequencer: next state, datapath control and result generation
  always_comb begin
    state_nxt     = state_r;
    remaining_nxt = remaining_r;
    cmd_ok_nxt    = cmd_ok_r;
    flag_nxt      = flag_r;
    status_nxt    = status_r;
    mstate_nxt    = mstate_r;
    fidx_nxt      = fidx_r;
    bidx_nxt      = bidx_r;
    bit_nxt       = bit_r;
    crc_nxt       = crc_r;
    cur_byte_nxt  = cur_byte_r;
    vld_q_nxt     = vld_q_r;
    frame_we      = 1'b0;
    frame_widx    = '0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_tx_nxt    = out_tx_r;
    out_flush_nxt = out_flush_r;
    out_last_nxt  = out_last_r;
    out_act_nxt   = out_act_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_func)
            FUNC_SENSOR: ram_we     = sidx_ok;
            FUNC_STATUS: status_nxt = in_data_byte;
            FUNC_MSTATE: mstate_nxt = in_data_byte;
            default: begin
              // Received SPI byte
              priority if (in_data_byte == START_BYTE) begin
                frame_we      = 1'b1;
                frame_widx    = '0;
                remaining_nxt = REM_OPEN;
                cmd_ok_nxt    = 1'b0;
                flag_nxt      = 1'b1;
                state_nxt     = ST_FLUSH;
              end else if (remaining_r != '0) begin
                frame_we      = 1'b1;
                frame_widx    = FRAME_LEN_F - remaining_r;
                remaining_nxt = remaining_r - 1'b1;
                if (remaining_r == FIW'(1)) begin
                  fidx_nxt  = '0;
                  bit_nxt   = '0;
                  crc_nxt   = init_r;
                  state_nxt = ST_CRC;
                end
              end else if (cmd_ok_r) begin
                cmd_ok_nxt = 1'b0;
                bidx_nxt   = '0;
                crc_nxt    = init_r;
                state_nxt  = ST_BURST_RD;
              end else begin
                state_nxt = ST_IDLE;
              end
            end
          endcase
        end
      end

      ST_FLUSH: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_tx_nxt    = 8'h00;
          out_flush_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          out_act_nxt   = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      ST_CRC: begin
        // Check the frame, one bit per cycle
        crc_nxt = crc_step;
        bit_nxt = bit_r + 1'b1;
        if (bit_r == 3'd7) begin
          if (fidx_r == FRAME_CRC_LAST) begin
            state_nxt = ST_ANSWER;
          end else begin
            fidx_nxt = fidx_r + 1'b1;
          end
        end
      end

      ST_ANSWER: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_tx_nxt    = (crc_fin == frame_got) ? PASS_BYTE : FAIL_BYTE;
          out_flush_nxt = 1'b0;
          out_last_nxt  = 1'b1;
          out_act_nxt   = flag_r;
          cmd_ok_nxt    = (crc_fin == frame_got);
          state_nxt     = ST_IDLE;
        end
      end

      ST_BURST_RD: begin
        ram_re    = sens_rd;
        vld_q_nxt = sens_rd ? sens_vld_r[ram_raddr] : 1'b0;
        state_nxt = ST_BURST_LD;
      end

      ST_BURST_LD: begin
        priority if (bidx_r == IDX_STATUS) begin
          cur_byte_nxt = status_r;
        end else if (bidx_r == IDX_MSTATE) begin
          cur_byte_nxt = mstate_r;
        end else begin
          cur_byte_nxt = vld_q_r ? ram_rdata : 8'h00;
        end
        state_nxt = ST_BURST_EMIT;
      end

      ST_BURST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_tx_nxt    = cur_byte_r;
          out_flush_nxt = 1'b0;
          out_last_nxt  = 1'b0;
          out_act_nxt   = flag_r;
          bit_nxt       = '0;
          state_nxt     = ST_BURST_CRC;
        end
      end

      ST_BURST_CRC: begin
        crc_nxt = crc_step;
        bit_nxt = bit_r + 1'b1;
        if (bit_r == 3'd7) begin
          if (bidx_r == IDX_MSTATE) begin
            state_nxt = ST_CRC_LO;
          end else begin
            bidx_nxt  = bidx_r + 1'b1;
            state_nxt = ST_BURST_RD;
          end
        end
      end

      ST_CRC_LO: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_tx_nxt    = crc_fin[7:0];
          out_flush_nxt = 1'b0;
          out_last_nxt  = 1'b0;
          out_act_nxt   = flag_r;
          state_nxt     = ST_CRC_HI;
        end
      end

      ST_CRC_HI: begin
        // Close the transfer with the checksum high byte
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_tx_nxt    = crc_fin[15:8];
          out_flush_nxt = 1'b0;
          out_last_nxt  = 1'b1;
          out_act_nxt   = 1'b0;
          flag_nxt      = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      remaining_r <= '0;
      cmd_ok_r    <= 1'b0;
      flag_r      <= 1'b0;
      status_r    <= 8'h00;
      mstate_r    <= 8'h00;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      remaining_r <= remaining_nxt;
      cmd_ok_r    <= cmd_ok_nxt;
      flag_r      <= flag_nxt;
      status_r    <= status_nxt;
      mstate_r    <= mstate_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    fidx_r      <= fidx_nxt;
    bidx_r      <= bidx_nxt;
    bit_r       <= bit_nxt;
    crc_r       <= crc_nxt;
    cur_byte_r  <= cur_byte_nxt;
    vld_q_r     <= vld_q_nxt;
    out_tx_r    <= out_tx_nxt;
    out_flush_r <= out_flush_nxt;
    out_last_r  <= out_last_nxt;
    out_act_r   <= out_act_nxt;
  end

  // Capture frame bytes
  always_ff @(posedge clk) begin
    if (frame_we) begin
      frame_r[frame_widx] <= in_data_byte;
    end
  end

  // Mark sensor entries as written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_vld_r <= '0;
    end else if (ram_we) begin
      sens_vld_r[ram_waddr] <= 1'b1;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_tx_byte         = out_tx_r;
  assign out_flush_tx        = out_flush_r;
  assign out_last            = out_last_r;
  assign out_transfer_active = out_act_r;

  // A flush transaction is always a lone, active, empty result
  a_flush_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_flush_r |-> out_last_r && out_act_r && (out_tx_r == 8'h00))
    else $error("flush result malformed");

  // Burst bytes before the final one carry a raised transfer flag
  a_burst_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |-> out_act_r)
    else $error("burst result without transfer flag");

  // An open frame implies the transfer flag is set
  a_frame_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (remaining_r != '0) |-> flag_r)
    else $error("frame open with transfer flag clear");

  // A pending match only exists with no open frame and an active transfer
  a_match_pending: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_ok_r |-> (remaining_r == '0) && flag_r)
    else $error("command match pending in wrong state");

  // Buffer writes never start the sequencer
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_func != FUNC_RX) |=> (state_r == ST_IDLE))
    else $error("write transaction left idle");

endmodule
